// ===== sv/ale_pkg.sv =====
// ale_pkg: shared types and codes of the array list engine
// no dependencies; used by the interfaces, the cell and the top level
`default_nettype none

package ale_pkg;

	// request operations
	localparam logic [2:0] OP_APPEND  = 3'd0;
	localparam logic [2:0] OP_INSERT  = 3'd1;
	localparam logic [2:0] OP_REMOVE  = 3'd2;
	localparam logic [2:0] OP_FIND    = 3'd3;
	localparam logic [2:0] OP_REPLACE = 3'd4;
	localparam logic [2:0] OP_READ    = 3'd5;

	// response status
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_NOTFOUND = 2'd2;
	localparam logic [1:0] STAT_RANGE    = 2'd3;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] value;
		logic [3:0]         index;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [2:0]         found_index;
		logic signed [31:0] read_value;
		logic [3:0]         count;
		logic               is_empty;
		logic               is_full;
	} rsp_t;

	// broadcast controls from the sequencer to every cell
	typedef struct packed {
		logic capture;
		logic ins;
		logic app;
		logic rem;
		logic rep;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== sv/ale_req_if.sv =====
// ale_req_if: request channel of the array list engine
// depends on ale_pkg
`default_nettype none

interface ale_req_if;
	logic          valid;
	logic          ready;
	ale_pkg::req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/ale_rsp_if.sv =====
// ale_rsp_if: response channel of the array list engine
// depends on ale_pkg
`default_nettype none

interface ale_rsp_if;
	logic          valid;
	logic          ready;
	ale_pkg::rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/ale_cell.sv =====
// ale_cell: one list slot, with its compare, read tap and neighbor shift
// depends on ale_pkg
`default_nettype none

module ale_cell #(
	parameter int POS = 0,
	parameter int IW  = 4
) (
	input  logic               clk,
	input  ale_pkg::cell_ctl_t ctl,
	input  logic [31:0]        word,
	input  logic [IW-1:0]      idx,
	input  logic [IW-1:0]      cnt,
	input  logic               ge_pos,
	input  logic [31:0]        prev_word,
	input  logic [31:0]        next_word,
	output logic [31:0]        entry,
	output logic               match,
	output logic [31:0]        rd_word
);

	localparam logic [IW-1:0] POS_V = IW'(POS);

	logic [31:0] entry_q;
	logic [31:0] entry_d;
	logic [31:0] rd_q;
	logic        match_q;

	always_comb begin
		entry_d = entry_q;
		if (ctl.ins) begin
			if (POS_V == idx) begin
				entry_d = word;
			end else if (POS_V > idx) begin
				entry_d = prev_word;
			end
		end
		if (ctl.app && (POS_V == cnt)) begin
			entry_d = word;
		end
		if (ctl.rep && (POS_V == idx)) begin
			entry_d = word;
		end
		if (ctl.rem && ge_pos) begin
			entry_d = next_word;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
		if (ctl.capture) begin
			match_q <= (POS_V < cnt) && (entry_q == word);
			rd_q    <= ((POS_V == idx) && (POS_V < cnt)) ? entry_q : '0;
		end
	end

	assign entry   = entry_q;
	assign match   = match_q;
	assign rd_word = rd_q;

endmodule

`default_nettype wire

// ===== sv/array_list_engine.sv =====
// array_list_engine: ordered list of 32-bit words held in a row of cells
// depends on ale_pkg, ale_req_if, ale_rsp_if and ale_cell
`default_nettype none

// The list lives in a row of DEPTH cells, one word each. On the accept edge
// every cell compares its word with the request value and taps its word for
// a read, all in parallel. In the following cycle the first match is picked,
// the cells shift up (insert) or down (remove) by taking their neighbor's
// word, or load the new word, and the response beat is registered. The
// response beat is valid from the edge that ends the update cycle, and no
// new request is taken during the update cycle, since the compare-then-update
// pass over the cell row must finish first. A waiting response beat does not
// block the next request once the sink takes it in the same cycle. Entries
// above the count are never reported; found_index and count are cut to their
// port widths when DEPTH exceeds them.

module array_list_engine #(
	parameter int DEPTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	ale_req_if.sink    req,
	ale_rsp_if.source  rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (CW > 4) ? CW : 4;
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [IW-1:0] FULL_V = IW'(DEPTH);

	// sequencer states
	localparam logic [0:0] S_IDLE = 1'b0;
	localparam logic [0:0] S_UPD  = 1'b1;

	logic [0:0]    state_q;
	logic [CW-1:0] cnt_q;
	ale_pkg::req_t req_q;
	ale_pkg::rsp_t rsp_q;
	logic          rsp_valid_q;

	logic          accept;
	logic [IW-1:0] cnt_ext;
	logic [IW-1:0] idx_bus;
	logic [31:0]   word_bus;
	logic          full;

	// cell row wiring
	logic [DEPTH-1:0] match;
	logic [DEPTH-1:0] lowbit;
	logic [DEPTH-1:0] ge_mask;
	logic [31:0]      entry   [DEPTH];
	logic [31:0]      rd_word [DEPTH];

	logic [PW-1:0] first_pos;
	logic [31:0]   rd_or;
	logic          any_match;

	ale_pkg::cell_ctl_t ctl;
	logic [1:0]         status;
	logic [CW-1:0]      cnt_next;
	logic [31:0]        read_val;
	logic [PW-1:0]      found;

	// a request is taken only when the response slot is free by the update cycle
	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	assign cnt_ext = IW'(cnt_q);
	assign full    = (cnt_ext == FULL_V);

	// the accept cycle drives the port request, the update cycle the held one
	assign idx_bus  = (state_q == S_UPD) ? IW'(req_q.index) : IW'(req.data.index);
	assign word_bus = (state_q == S_UPD) ? req_q.value : req.data.value;

	// first match and everything at or above it
	assign lowbit    = match & (~match + DEPTH'(1));
	assign ge_mask   = ~(lowbit - DEPTH'(1));
	assign any_match = |match;

	always_comb begin
		first_pos = '0;
		rd_or     = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (lowbit[i]) begin
				first_pos = first_pos | PW'(i);
			end
			rd_or = rd_or | rd_word[i];
		end
	end

	generate
		for (genvar g = 0; g < DEPTH; g++) begin : g_cell
			logic [31:0] prev_w;
			logic [31:0] next_w;
			if (g == 0) begin : g_first
				assign prev_w = '0;
			end else begin : g_mid_lo
				assign prev_w = entry[g-1];
			end
			if (g == DEPTH - 1) begin : g_last
				assign next_w = '0;
			end else begin : g_mid_hi
				assign next_w = entry[g+1];
			end
			ale_cell #(
				.POS (g),
				.IW  (IW)
			) u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.word      (word_bus),
				.idx       (idx_bus),
				.cnt       (cnt_ext),
				.ge_pos    (ge_mask[g]),
				.prev_word (prev_w),
				.next_word (next_w),
				.entry     (entry[g]),
				.match     (match[g]),
				.rd_word   (rd_word[g])
			);
		end
	endgenerate

	// decode of the held request during the update cycle
	always_comb begin
		ctl         = '0;
		ctl.capture = accept;
		status      = ale_pkg::STAT_OK;
		cnt_next    = cnt_q;
		read_val    = '0;
		found       = '0;
		case (req_q.op)
			ale_pkg::OP_APPEND: begin
				if (full) begin
					status = ale_pkg::STAT_FULL;
				end else begin
					ctl.app  = 1'b1;
					cnt_next = cnt_q + CW'(1);
				end
			end
			ale_pkg::OP_INSERT: begin
				if (full) begin
					status = ale_pkg::STAT_FULL;
				end else if (idx_bus > cnt_ext) begin
					status = ale_pkg::STAT_RANGE;
				end else begin
					ctl.ins  = 1'b1;
					cnt_next = cnt_q + CW'(1);
				end
			end
			ale_pkg::OP_REMOVE: begin
				if (!any_match) begin
					status = ale_pkg::STAT_NOTFOUND;
				end else begin
					ctl.rem  = 1'b1;
					found    = first_pos;
					cnt_next = cnt_q - CW'(1);
				end
			end
			ale_pkg::OP_FIND: begin
				if (!any_match) begin
					status = ale_pkg::STAT_NOTFOUND;
				end else begin
					found = first_pos;
				end
			end
			ale_pkg::OP_REPLACE: begin
				if (idx_bus >= cnt_ext) begin
					status = ale_pkg::STAT_RANGE;
				end else begin
					ctl.rep = 1'b1;
				end
			end
			ale_pkg::OP_READ: begin
				if (idx_bus >= cnt_ext) begin
					status = ale_pkg::STAT_RANGE;
				end else begin
					read_val = rd_or;
				end
			end
			default: begin
				// unused codes leave the list as it is
			end
		endcase
		if (state_q != S_UPD) begin
			ctl.ins  = 1'b0;
			ctl.app  = 1'b0;
			ctl.rem  = 1'b0;
			ctl.rep  = 1'b0;
			cnt_next = cnt_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_next;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_UPD;
					end
					if (rsp.ready) begin
						rsp_valid_q <= 1'b0;
					end
				end
				S_UPD: begin
					state_q     <= S_IDLE;
					rsp_valid_q <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request hold and response beat
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req.data;
		end
		if (state_q == S_UPD) begin
			rsp_q.status      <= status;
			rsp_q.found_index <= 3'(found);
			rsp_q.read_value  <= read_val;
			rsp_q.count       <= 4'(cnt_next);
			rsp_q.is_empty    <= (cnt_next == '0);
			rsp_q.is_full     <= (IW'(cnt_next) == FULL_V);
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

`ifndef SYNTHESIS
	a_upd_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) |=> rsp_valid_q)
		else $error("update cycle did not produce a response beat");

	a_busy_no_req: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) |-> !req.ready)
		else $error("request taken during update");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_ext <= FULL_V)
		else $error("entry count above capacity");

	a_first_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) |-> $onehot0(lowbit))
		else $error("more than one first match");

	a_find_keeps_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && req_q.op == ale_pkg::OP_FIND) |=> $stable(cnt_q))
		else $error("find changed the count");
`endif

endmodule

`default_nettype wire
